// ===== hdl/mpm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpm_pkg
// Shared types, widths and modular add/subtract helpers for the power mixer.
// ----------------------------------------------------------------------------
package mpm_pkg;

  localparam int DW   = 63;
  localparam int EXPW = 7;

  typedef struct packed {
    logic          first;
    logic [DW-1:0] a_value;
    logic [DW-1:0] b_power;
  } in_beat_t;

  typedef struct packed {
    logic [DW-1:0]   a_power;
    logic [EXPW-1:0] exponent;
    logic            overflow;
  } out_beat_t;

  // Sum of two reduced values, brought back below the modulus.
  function automatic logic [DW-1:0] add_mod(input logic [DW-1:0] x,
                                            input logic [DW-1:0] y,
                                            input logic [DW-1:0] p);
    logic [DW:0] s;
    logic [DW:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, p};
    return (s >= {1'b0, p}) ? d[DW-1:0] : s[DW-1:0];
  endfunction

  // Difference of two reduced values, wrapped into the field.
  function automatic logic [DW-1:0] sub_mod(input logic [DW-1:0] x,
                                            input logic [DW-1:0] y,
                                            input logic [DW-1:0] p);
    return (x >= y) ? (x - y) : (x + (p - y));
  endfunction

endpackage

// ===== hdl/mpm_modred.sv =====
// ----------------------------------------------------------------------------
// mpm_modred
// Iterative reduction x mod p, one quotient bit per cycle (restoring).
// ----------------------------------------------------------------------------
module mpm_modred
  import mpm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] x,
  input  logic [DW-1:0] p,
  output logic          done,
  output logic [DW-1:0] r
);

  localparam int CNTW = $clog2(DW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   xs_r, xs_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   p_r, p_nxt;
  logic [DW:0]     trial;
  logic [DW:0]     trial_sub;

  // One restoring step: shift in the next dividend bit and subtract if possible.
  always_comb begin
    trial     = {rem_r, xs_r[DW-1]};
    trial_sub = trial - {1'b0, p_r};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    xs_nxt    = xs_r;
    rem_nxt   = rem_r;
    p_nxt     = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      xs_nxt   = x;
      rem_nxt  = '0;
      p_nxt    = p;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, p_r}) ? trial_sub[DW-1:0] : trial[DW-1:0];
      xs_nxt  = {xs_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    xs_r  <= xs_nxt;
    rem_r <= rem_nxt;
    p_r   <= p_nxt;
  end

  assign done = done_r;
  assign r    = rem_r;

endmodule

// ===== hdl/mpm_mulmod.sv =====
// ----------------------------------------------------------------------------
// mpm_mulmod
// Bit-serial modular multiply of two reduced operands, one multiplier bit
// per cycle with double-and-add.
// ----------------------------------------------------------------------------
module mpm_mulmod
  import mpm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] x,
  input  logic [DW-1:0] y,
  input  logic [DW-1:0] p,
  output logic          done,
  output logic [DW-1:0] r
);

  localparam int CNTW = $clog2(DW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   xa_r, xa_nxt;
  logic [DW-1:0]   yb_r, yb_nxt;
  logic [DW-1:0]   acc_r, acc_nxt;
  logic [DW-1:0]   p_r, p_nxt;

  // Add the shifted multiplicand when the current multiplier bit is set.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    xa_nxt   = xa_r;
    yb_nxt   = yb_r;
    acc_nxt  = acc_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      xa_nxt   = x;
      yb_nxt   = y;
      acc_nxt  = '0;
      p_nxt    = p;
    end else if (busy_r) begin
      if (yb_r[0]) begin
        acc_nxt = add_mod(acc_r, xa_r, p_r);
      end
      xa_nxt  = add_mod(xa_r, xa_r, p_r);
      yb_nxt  = {1'b0, yb_r[DW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    xa_r  <= xa_nxt;
    yb_r  <= yb_nxt;
    acc_r <= acc_nxt;
    p_r   <= p_nxt;
  end

  assign done = done_r;
  assign r    = acc_r;

endmodule

// ===== hdl/modular_power_mixing_top.sv =====
// ----------------------------------------------------------------------------
// modular_power_mixing_top
// Powers a^m in a prime field from a stream of b^m, using a stored diagonal
// row that is read, updated and written back entry by entry.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Beat
//  input     in_valid, in_ready, in_data    in_beat_t: first, a_value, b_power
//  result    out_valid, out_ready, out_data out_beat_t: a_power, exponent, overflow
//  config    cfg_we, cfg_wdata              modulus, written at once
//
// Item m first reduces b, and a as well when it starts a run, then the two held
// values; each of the m row entries then needs one read, a serial reduction
// and a serial multiply. An overflowing item skips the held values and the
// row walk. Reset needs no clearing pass.
// A new beat is taken only when the sequencer is idle; a finished result
// waits in the output register without blocking the next beat.
// ----------------------------------------------------------------------------
module modular_power_mixing_top
  import mpm_pkg::*;
#(
  parameter int MAX_POWERS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_beat_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_beat_t     out_data,
  input  logic          cfg_we,
  input  logic [DW-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_POWERS + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RED_B = 11'b000_0000_0010,
    S_RED_A = 11'b000_0000_0100,
    S_CHK   = 11'b000_0000_1000,
    S_RD0   = 11'b000_0001_0000,
    S_RED_HA= 11'b000_0010_0000,
    S_RED_HB= 11'b000_0100_0000,
    S_ITER  = 11'b000_1000_0000,
    S_RED_C = 11'b001_0000_0000,
    S_MUL   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [DW-1:0]   modulus_r;
  logic [DW-1:0]   mod_eff;
  logic [DW-1:0]   p_r, p_nxt;
  in_beat_t        beat_r, beat_nxt;
  logic [DW-1:0]   bm_r, bm_nxt;
  logic [DW-1:0]   ha_r, ha_nxt;
  logic [DW-1:0]   hb_r, hb_nxt;
  logic [AW-1:0]   step_r, step_nxt;
  logic [AW-1:0]   m_r, m_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic [DW-1:0]   diff_r, diff_nxt;
  logic [DW-1:0]   sum_r, sum_nxt;
  logic [DW-1:0]   carry_r, carry_nxt;
  logic [DW-1:0]   res_r, res_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_beat_t       out_data_r, out_data_nxt;

  logic [DW-1:0]   row_mem [0:MAX_POWERS];
  logic [DW-1:0]   rd_data_r;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [DW-1:0]   wr_data;

  logic            red_start, red_done;
  logic [DW-1:0]   red_x, red_r;
  logic [DW-1:0]   red_p;
  logic            mul_start, mul_done;
  logic [DW-1:0]   mul_y, mul_r;
  logic [DW-1:0]   new_entry;
  logic [AW+6:0]   m_ext;

  // Modulus register; 0 and 1 behave as 2 when sampled for an item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= DW'(2);
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  assign mod_eff = (modulus_r < DW'(2)) ? DW'(2) : modulus_r;

  mpm_modred u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .x     (red_x),
    .p     (red_p),
    .done  (red_done),
    .r     (red_r)
  );

  mpm_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (diff_r),
    .y     (mul_y),
    .p     (p_r),
    .done  (mul_done),
    .r     (mul_r)
  );

  // Diagonal row storage with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= row_mem[rd_addr];
    end
  end

  assign new_entry = add_mod(mul_r, bm_r, p_r);
  assign m_ext     = {7'b0, m_r};

  // Sequencer: reduce inputs, then, unless the run has overflowed, walk the row with the running prefix sum.
  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    beat_nxt      = beat_r;
    bm_nxt        = bm_r;
    ha_nxt        = ha_r;
    hb_nxt        = hb_r;
    step_nxt      = step_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    diff_nxt      = diff_r;
    sum_nxt       = sum_r;
    carry_nxt     = carry_r;
    res_nxt       = res_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    red_start     = 1'b0;
    red_x         = beat_r.b_power;
    red_p         = p_r;
    mul_start     = 1'b0;
    mul_y         = add_mod(sum_r, red_r, p_r);
    rd_en         = 1'b0;
    rd_addr       = i_r;
    wr_en         = 1'b0;
    wr_addr       = i_r;
    wr_data       = new_entry;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          beat_nxt  = in_data;
          p_nxt     = mod_eff;
          state_nxt = S_RED_B;
        end
      end
      S_RED_B: begin
        // The reduction of b_power was started as the beat was taken.
        if (red_done) begin
          bm_nxt = red_r;
          if (beat_r.first) begin
            red_x     = beat_r.a_value;
            red_start = 1'b1;
            state_nxt = S_RED_A;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_RED_A: begin
        if (red_done) begin
          ha_nxt    = red_r;
          hb_nxt    = bm_r;
          step_nxt  = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (step_r >= AW'(MAX_POWERS)) begin
          res_nxt   = '0;
          ovf_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        // Entry zero is one at the start of every run.
        carry_nxt = (step_r == '0) ? DW'(1) : rd_data_r;
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = bm_r;
        m_nxt     = step_r + 1'b1;
        i_nxt     = AW'(1);
        sum_nxt   = '0;
        red_x     = ha_r;
        red_start = 1'b1;
        state_nxt = S_RED_HA;
      end
      S_RED_HA: begin
        if (red_done) begin
          diff_nxt  = red_r;
          red_x     = hb_r;
          red_start = 1'b1;
          state_nxt = S_RED_HB;
        end
      end
      S_RED_HB: begin
        if (red_done) begin
          diff_nxt  = sub_mod(diff_r, red_r, p_r);
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        // Fetch the old entry at i before it is overwritten.
        rd_en     = 1'b1;
        red_x     = carry_r;
        red_start = 1'b1;
        state_nxt = S_RED_C;
      end
      S_RED_C: begin
        if (red_done) begin
          sum_nxt   = mul_y;
          carry_nxt = (i_r < m_r) ? rd_data_r : '0;
          mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          wr_en = 1'b1;
          if (i_r == m_r) begin
            res_nxt   = new_entry;
            step_nxt  = m_r;
            state_nxt = S_OUT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_ITER;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.a_power  = res_r;
          out_data_nxt.exponent = ovf_r ? '0 : m_ext[6:0];
          out_data_nxt.overflow = ovf_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Kick the reduction of b_power on the beat itself, under the current modulus.
    if (state_r == S_IDLE && in_valid) begin
      red_x     = in_data.b_power;
      red_p     = mod_eff;
      red_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ha_r        <= '0;
      hb_r        <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ha_r        <= ha_nxt;
      hb_r        <= hb_nxt;
      step_r      <= step_nxt;
    end
    p_r        <= p_nxt;
    beat_r     <= beat_nxt;
    bm_r       <= bm_nxt;
    m_r        <= m_nxt;
    i_r        <= i_nxt;
    diff_r     <= diff_nxt;
    sum_r      <= sum_nxt;
    carry_r    <= carry_nxt;
    res_r      <= res_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The step count never runs past the row length.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= AW'(MAX_POWERS))
    else $error("step count beyond row length");

  // An overflow beat carries no power and no exponent.
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.a_power == '0 && out_data.exponent == '0)
    else $error("overflow beat carries data");

  // After a beat is taken the sequencer is busy in the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // Row writes happen only while an item is being worked.
  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !in_ready)
    else $error("row written while idle");

endmodule

// ===== tb/sv/modular_power_mixing_top_tb.sv =====
// ----------------------------------------------------------------------------
// modular_power_mixing_top_tb
// Self-checking bench for the power mixer. Runs of b^m beats are sent under
// several field moduli. Each accepted beat is predicted against a local copy
// of the diagonal row, and the result beats are compared in order.
// ----------------------------------------------------------------------------
module modular_power_mixing_top_tb;
  import mpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_POWERS   = 64;
  localparam int unsigned STALL_LIMIT  = 50000;
  localparam int unsigned HOLDOFF_LEN  = 5000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [DW-1:0] ALL_ONES   = {DW{1'b1}};

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic          cfg_we;
  logic [DW-1:0] cfg_wdata;

  modular_power_mixing_top #(.MAX_POWERS(MAX_POWERS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Pending beats, expected results and error count.
  in_beat_t    pending_beats[$];
  out_beat_t   expected_powers[$];
  int unsigned error_count = 0;

  // Local copy of the field modulus and the mixer state.
  logic [DW-1:0] field_mod;
  logic [DW-1:0] row_copy[0:MAX_POWERS];
  logic [DW-1:0] run_a;
  logic [DW-1:0] run_b;
  int unsigned   run_steps;

  // Idle and hold-off controls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          holdoff_req   = 0;
  int unsigned holdoff_left  = 0;
  int unsigned quiet_cycles  = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [DW-1:0] eff_mod();
    return (field_mod < 2) ? DW'(2) : field_mod;
  endfunction

  function automatic logic [DW-1:0] mul_field(logic [DW-1:0] x, logic [DW-1:0] y,
                                              logic [DW-1:0] p);
    logic [127:0] prod;
    prod = 128'(x % p) * 128'(y % p);
    return DW'(prod % 128'(p));
  endfunction

  function automatic logic [DW-1:0] add_field(logic [DW-1:0] x, logic [DW-1:0] y,
                                              logic [DW-1:0] p);
    logic [DW:0] s;
    s = {1'b0, x % p} + {1'b0, y % p};
    return (s >= {1'b0, p}) ? DW'(s - {1'b0, p}) : s[DW-1:0];
  endfunction

  // Advances the local state by one beat and returns the result it causes.
  function automatic out_beat_t predict_power(in_beat_t beat);
    out_beat_t     res;
    logic [DW-1:0] p, bm, diff, sum, carry, old_here, ha, hb;
    int unsigned   m;
    p  = eff_mod();
    bm = beat.b_power % p;
    if (beat.first) begin
      foreach (row_copy[i]) row_copy[i] = '0;
      row_copy[0] = 1;
      run_steps = 0;
      run_a = beat.a_value % p;
      run_b = bm;
    end
    res = '0;
    if (run_steps >= MAX_POWERS) begin
      res.overflow = 1'b1;
      return res;
    end
    m  = run_steps + 1;
    ha = run_a % p;
    hb = run_b % p;
    diff  = (ha >= hb) ? ha - hb : ha + (p - hb);
    sum   = '0;
    carry = row_copy[0];
    row_copy[0] = bm;
    for (int unsigned i = 1; i <= m; i++) begin
      old_here = (i < m) ? row_copy[i] : '0;
      sum   = add_field(sum, carry, p);
      carry = old_here;
      row_copy[i] = add_field(mul_field(diff, sum, p), bm, p);
    end
    run_steps    = m;
    res.a_power  = row_copy[m];
    res.exponent = EXPW'(m);
    return res;
  endfunction

  function automatic logic [DW-1:0] rand_field();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return ALL_ONES - 1;
      default: return DW'({$urandom, $urandom});
    endcase
  endfunction

  // Queues one run of len beats; mostly true powers of b, sometimes noise.
  task automatic queue_run(int unsigned len, bit with_first);
    in_beat_t      beat;
    logic [DW-1:0] base, cur;
    bit            real_powers;
    base = rand_field();
    cur  = base % eff_mod();
    real_powers = ($urandom_range(99) < 80);
    for (int unsigned k = 0; k < len; k++) begin
      beat.first   = with_first && (k == 0);
      beat.a_value = rand_field();
      beat.b_power = real_powers ? cur : rand_field();
      if (real_powers && $urandom_range(19) == 0) beat.b_power = base;
      pending_beats.push_back(beat);
      cur = mul_field(cur, base, eff_mod());
    end
  endtask

  // Waits for every beat to be sent and every result to be checked.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_powers.size() != 0 || in_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_modulus(logic [DW-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    field_mod  = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: offers pending beats and holds each until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data  <= pending_beats.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else if (holdoff_req) begin
      holdoff_req  <= 1'b0;
      holdoff_left <= HOLDOFF_LEN;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on each input beat and checks each result beat.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) expected_powers.push_back(predict_power(in_data));
      if (out_valid && out_ready) begin
        if (expected_powers.size() == 0) begin
          $display("ERROR %0t: result beat with nothing pending", $realtime);
          error_count++;
        end else begin
          want = expected_powers.pop_front();
          if (out_data.a_power !== want.a_power)
            report_mismatch("a_power", out_data.a_power, want.a_power);
          if (out_data.exponent !== want.exponent)
            report_mismatch("exponent", DW'(out_data.exponent), DW'(want.exponent));
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", DW'(out_data.overflow), DW'(want.overflow));
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [DW-1:0] moduli[7];
    in_beat_t      beat;
    int unsigned   sent;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    field_mod = DW'(2);
    foreach (row_copy[i]) row_copy[i] = '0;
    row_copy[0] = 1;
    run_a = '0;
    run_b = '0;
    run_steps = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: beats with no first after reset, under the reset modulus.
    send_idle_pct = 21;
    recv_idle_pct = 82;
    queue_run(2, 0);
    // Modulus zero and one behave as two; the run carries over.
    write_modulus('0);
    queue_run(2, 0);
    write_modulus(DW'(1));
    queue_run(2, 1);
    // Largest modulus with field extremes in a and b.
    write_modulus(ALL_ONES);
    beat = '{first: 1'b1, a_value: ALL_ONES, b_power: ALL_ONES};
    pending_beats.push_back(beat);
    beat = '{first: 1'b0, a_value: '0, b_power: ALL_ONES - 1};
    pending_beats.push_back(beat);
    beat = '{first: 1'b1, a_value: ALL_ONES - 1, b_power: '0};
    pending_beats.push_back(beat);
    beat = '{first: 1'b0, a_value: ALL_ONES, b_power: DW'(1)};
    pending_beats.push_back(beat);
    beat = '{first: 1'b1, a_value: '0, b_power: ALL_ONES - 1};
    pending_beats.push_back(beat);
    beat = '{first: 1'b0, a_value: '0, b_power: '0};
    pending_beats.push_back(beat);
    // Non-prime modulus, then a change in the middle of the same run.
    write_modulus(DW'(12));
    queue_run(3, 1);
    write_modulus(DW'(7));
    queue_run(2, 0);

    // Random phases over several moduli.
    moduli = '{ALL_ONES, DW'(63'h1FFF_FFFF_FFFF_FFFF), DW'(1000000007), DW'(12),
               DW'(3), DW'(2), DW'({$urandom, $urandom} | 63'h4000_0000_0000_0000)};
    sent = 0;
    foreach (moduli[ph]) begin
      if (ph < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 82;
      end else if (ph < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_modulus(moduli[ph]);
      // One full run past the power limit, so the overflow path is taken.
      if (ph == 2) begin
        queue_run(MAX_POWERS + 3, 1);
        queue_run(2, 0);
        queue_run(2, 1);
      end
      if (ph == 4) holdoff_req = 1'b1;
      for (int unsigned n = 0; n < 290; ) begin
        int unsigned len;
        len = ($urandom_range(19) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        queue_run(len, $urandom_range(9) != 0);
        n += len;
        sent += len;
        // Keep the queue short so that idling spreads over the phase.
        while (pending_beats.size() > 8) @(posedge clk);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
